// ===== rtl/core/wide_line_quad_expander_core_macros.svh =====
// Assertion macros shared by the wide line quad expander RTL.
`ifndef WIDE_LINE_QUAD_EXPANDER_CORE_MACROS_SVH
`define WIDE_LINE_QUAD_EXPANDER_CORE_MACROS_SVH
`ifndef ASSERT_OFF
// Check that a property holds on every rising clock edge outside reset.
`define WLQE_ASSERT(lbl, clock, reset, prop) \
  lbl: assert property (@(posedge clock) disable iff (reset) (prop)) \
    else $error("wlqe assertion failed");
// Check that a condition never comes true outside reset.
`define WLQE_ASSERT_NEVER(lbl, clock, reset, cond) \
  lbl: assert property (@(posedge clock) disable iff (reset) !(cond)) \
    else $error("wlqe forbidden condition seen");
`else
`define WLQE_ASSERT(lbl, clock, reset, prop)
`define WLQE_ASSERT_NEVER(lbl, clock, reset, cond)
`endif
`endif

// ===== rtl/core/wlqe_pkg.sv =====
// Shared constants and types of the wide line quad expander.
package wlqe_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;
  // Fraction bits of the internal unit normal
  localparam int UNIT_BITS       = 30;
  localparam int QUEUE_DEPTH     = 2;

  typedef struct packed {
    logic full;
    logic empty;
  } wlqe_q_stat_t;

endpackage

// ===== rtl/core/wlqe_queue.sv =====
// Small register queue between the front and back parts.
module wlqe_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr,
  input  logic [WIDTH-1:0]      wdata,
  input  logic                  rd,
  output logic [WIDTH-1:0]      rdata,
  output wlqe_pkg::wlqe_q_stat_t stat
);
  import wlqe_pkg::*;

  localparam int PW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wptr;
  logic [PW-1:0]    rptr;
  logic [PW:0]      count;
  logic             do_wr;
  logic             do_rd;

  assign stat.full  = (count == (PW+1)'(DEPTH));
  assign stat.empty = (count == '0);
  assign do_wr = wr && !stat.full;
  assign do_rd = rd && !stat.empty;
  assign rdata = mem[rptr];

  // store pushed entries
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wptr] <= wdata;
    end
  end

  // advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wptr <= (wptr == PW'(DEPTH-1)) ? '0 : wptr + 1'b1;
      end
      if (do_rd) begin
        rptr <= (rptr == PW'(DEPTH-1)) ? '0 : rptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/wlqe_front.sv =====
// Front part: accepts segments, drops zero-length ones, sets non-positive widths to 1.0, prepares operands.
module wlqe_front #(
  parameter int COORD_WIDTH = wlqe_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = wlqe_pkg::FRAC_BITS_DEF
) (
  input  logic                          push,
  output logic                          full,
  input  logic signed [COORD_WIDTH-1:0] start_x,
  input  logic signed [COORD_WIDTH-1:0] start_y,
  input  logic signed [COORD_WIDTH-1:0] end_x,
  input  logic signed [COORD_WIDTH-1:0] end_y,
  input  logic signed [COORD_WIDTH-1:0] line_width,
  input  wlqe_pkg::wlqe_q_stat_t        q_stat,
  output logic                          q_push,
  output logic [7*COORD_WIDTH+1:0]      q_data
);
  import wlqe_pkg::*;

  localparam int CW = COORD_WIDTH;

  logic signed [CW:0] dx;
  logic signed [CW:0] dy;
  logic [CW:0]        dx_mag;
  logic [CW:0]        dy_mag;
  logic [CW-1:0]      width_fix;
  logic               zero_len;

  // form the direction and its magnitudes
  always_comb begin
    dx = $signed({end_x[CW-1], end_x}) - $signed({start_x[CW-1], start_x});
    dy = $signed({end_y[CW-1], end_y}) - $signed({start_y[CW-1], start_y});
    dx_mag = dx[CW] ? (~dx + 1'b1) : dx;
    dy_mag = dy[CW] ? (~dy + 1'b1) : dy;
    zero_len = (start_x == end_x) && (start_y == end_y);
    width_fix = (line_width[CW-1] || (line_width == '0)) ?
                (CW'(1) << FRAC_BITS) : line_width;
  end

  assign full   = q_stat.full;
  assign q_push = push && !q_stat.full && !zero_len;
  assign q_data = {start_x, start_y, end_x, end_y, width_fix, dx[CW], dy[CW],
                   dx_mag[CW-1:0], dy_mag[CW-1:0]};

endmodule

// ===== rtl/core/wlqe_back.sv =====
// Back part: normalizes, takes the root, divides and scales, forms corners.
module wlqe_back #(
  parameter int COORD_WIDTH = wlqe_pkg::COORD_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  wlqe_pkg::wlqe_q_stat_t   q_stat,
  input  logic [7*COORD_WIDTH+1:0] q_data,
  output logic                     q_pop,
  output logic                     c_valid,
  input  logic                     c_ready,
  output logic [COORD_WIDTH-1:0]   cx [4],
  output logic [COORD_WIDTH-1:0]   cy [4]
);
  import wlqe_pkg::*;

  localparam int CW    = COORD_WIDTH;
  localparam int UB    = UNIT_BITS;
  localparam int AW    = (CW > UB) ? CW : UB;
  localparam int STEPS = UB + 1;
  localparam int CNTW  = $clog2(STEPS);
  localparam int PW    = CW + UB + 1;
  localparam logic [AW:0] NORM_TOP  = (AW+1)'(1) << UB;
  localparam logic [AW:0] NORM_HALF = (AW+1)'(1) << (UB - 1);
  localparam logic [AW:0] NORM_FAR  = (AW+1)'(1) << (UB - 9);
  localparam logic signed [CW+1:0] SAT_MAX = {3'b000, {(CW-1){1'b1}}};
  localparam logic signed [CW+1:0] SAT_MIN = {3'b111, {(CW-1){1'b0}}};

  typedef enum logic [3:0] {
    IDLE, NORM, SQR, SUM, ROOT, PREP, DIV, FIN, CORN, HAND
  } state_t;

  state_t                state;
  logic signed [CW-1:0]  sx, sy, ex, ey;
  logic [CW-1:0]         wm;
  logic                  dxn, dyn;
  logic [AW-1:0]         a [2];
  logic [2*UB-1:0]       sq [2];
  logic [2*UB:0]         rad;
  logic [2*UB:0]         res;
  logic [2*UB:0]         sbit;
  logic [CNTW-1:0]       cnt;
  logic [UB:0]           rem [2];
  logic [UB:0]           low [2];
  logic [PW-1:0]         acc [2];
  logic [CW-1:0]         hm [2];

  logic [AW:0]           mx;
  logic [2*UB+1:0]       tsum;
  logic                  root_ge;
  logic [UB:0]           len;
  logic [2*UB:0]         num [2];
  logic [UB+1:0]         trial [2];
  logic                  div_ge [2];
  logic [UB:0]           rem_next [2];
  logic [PW-1:0]         acc_next [2];
  logic [PW-1:0]         acc_round [2];
  logic signed [CW:0]    hx, hy;

  function automatic logic [CW-1:0] sat(input logic signed [CW+1:0] v);
    logic signed [CW+1:0] t;
    t = v;
    if (v > SAT_MAX) begin
      t = SAT_MAX;
    end else if (v < SAT_MIN) begin
      t = SAT_MIN;
    end
    return t[CW-1:0];
  endfunction

  function automatic logic signed [CW+1:0] ext_c(input logic signed [CW-1:0] v);
    return $signed({{2{v[CW-1]}}, v});
  endfunction

  function automatic logic signed [CW+1:0] ext_h(input logic signed [CW:0] v);
    return $signed({v[CW], v});
  endfunction

  // step logic of the root, divide and scale iterations
  always_comb begin
    mx      = {1'b0, (a[0] > a[1]) ? a[0] : a[1]};
    tsum    = {1'b0, res} + {1'b0, sbit};
    root_ge = ({1'b0, rad} >= tsum);
    len     = res[UB:0];
    for (int i = 0; i < 2; i++) begin
      num[i]       = {1'b0, a[i][UB-1:0], UB'(0)} + (2*UB+1)'(len >> 1);
      trial[i]     = {rem[i], low[i][UB]};
      div_ge[i]    = (trial[i] >= {1'b0, len});
      rem_next[i]  = div_ge[i] ? (UB+1)'(trial[i] - {1'b0, len}) : (UB+1)'(trial[i]);
      acc_next[i]  = (acc[i] << 1) + (div_ge[i] ? PW'(wm) : '0);
      acc_round[i] = acc[i] + (PW'(1) << UB);
    end
    // offset follows the left normal (-uy, ux)
    hx = dyn ? $signed({1'b0, hm[1]}) : -$signed({1'b0, hm[1]});
    hy = dxn ? -$signed({1'b0, hm[0]}) : $signed({1'b0, hm[0]});
  end

  assign q_pop   = (state == IDLE) && !q_stat.empty;
  assign c_valid = (state == HAND);

  // sequence one segment through the shared units
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      case (state)
        IDLE: begin
          if (!q_stat.empty) begin
            {sx, sy, ex, ey, wm, dxn, dyn} <= q_data[7*CW+1:2*CW];
            a[0]  <= AW'(q_data[2*CW-1:CW]);
            a[1]  <= AW'(q_data[CW-1:0]);
            state <= NORM;
          end
        end
        NORM: begin
          if (mx >= NORM_TOP) begin
            a[0] <= a[0] >> 1;
            a[1] <= a[1] >> 1;
          end else if (mx < NORM_FAR) begin
            a[0] <= a[0] << 8;
            a[1] <= a[1] << 8;
          end else if (mx < NORM_HALF) begin
            a[0] <= a[0] << 1;
            a[1] <= a[1] << 1;
          end else begin
            state <= SQR;
          end
        end
        SQR: begin
          sq[0] <= a[0][UB-1:0] * a[0][UB-1:0];
          sq[1] <= a[1][UB-1:0] * a[1][UB-1:0];
          state <= SUM;
        end
        SUM: begin
          rad   <= {1'b0, sq[0]} + {1'b0, sq[1]};
          res   <= '0;
          sbit  <= (2*UB+1)'(1) << (2*UB);
          cnt   <= '0;
          state <= ROOT;
        end
        ROOT: begin
          if (root_ge) begin
            rad <= rad - tsum[2*UB:0];
            res <= (res >> 1) + sbit;
          end else begin
            res <= res >> 1;
          end
          sbit <= sbit >> 2;
          cnt  <= cnt + 1'b1;
          if (cnt == CNTW'(STEPS - 1)) begin
            state <= PREP;
          end
        end
        PREP: begin
          for (int i = 0; i < 2; i++) begin
            rem[i] <= {1'b0, num[i][2*UB:UB+1]};
            low[i] <= num[i][UB:0];
            acc[i] <= '0;
          end
          cnt   <= '0;
          state <= DIV;
        end
        DIV: begin
          for (int i = 0; i < 2; i++) begin
            rem[i] <= rem_next[i];
            low[i] <= low[i] << 1;
            acc[i] <= acc_next[i];
          end
          cnt <= cnt + 1'b1;
          if (cnt == CNTW'(STEPS - 1)) begin
            state <= FIN;
          end
        end
        FIN: begin
          for (int i = 0; i < 2; i++) begin
            hm[i] <= acc_round[i][PW-1:UB+1];
          end
          state <= CORN;
        end
        CORN: begin
          cx[0] <= sat(ext_c(sx) + ext_h(hx));
          cy[0] <= sat(ext_c(sy) + ext_h(hy));
          cx[1] <= sat(ext_c(sx) - ext_h(hx));
          cy[1] <= sat(ext_c(sy) - ext_h(hy));
          cx[2] <= sat(ext_c(ex) - ext_h(hx));
          cy[2] <= sat(ext_c(ey) - ext_h(hy));
          cx[3] <= sat(ext_c(ex) + ext_h(hx));
          cy[3] <= sat(ext_c(ey) + ext_h(hy));
          state <= HAND;
        end
        HAND: begin
          if (c_ready) begin
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/wlqe_emit.sv =====
// Result stage: holds four corners and hands out the two triangles in turn.
module wlqe_emit #(
  parameter int COORD_WIDTH = wlqe_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          c_valid,
  output logic                          c_ready,
  input  logic [COORD_WIDTH-1:0]        cx [4],
  input  logic [COORD_WIDTH-1:0]        cy [4],
  input  logic                          pop,
  output logic                          empty,
  output logic signed [COORD_WIDTH-1:0] vert0_x,
  output logic signed [COORD_WIDTH-1:0] vert0_y,
  output logic signed [COORD_WIDTH-1:0] vert1_x,
  output logic signed [COORD_WIDTH-1:0] vert1_y,
  output logic signed [COORD_WIDTH-1:0] vert2_x,
  output logic signed [COORD_WIDTH-1:0] vert2_y,
  output logic                          last_triangle
);
  import wlqe_pkg::*;

  logic [COORD_WIDTH-1:0] hx [4];
  logic [COORD_WIDTH-1:0] hy [4];
  logic                   valid;
  logic                   phase;

  assign c_ready = !valid;
  assign empty   = !valid;

  // hold corners until both triangles are taken
  always_ff @(posedge clk) begin
    if (c_valid && !valid) begin
      hx <= cx;
      hy <= cy;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      phase <= 1'b0;
    end else if (!valid) begin
      valid <= c_valid;
      phase <= 1'b0;
    end else if (pop) begin
      phase <= !phase;
      valid <= !phase;
    end
  end

  // first triangle s+h, s-h, e-h; second s+h, e-h, e+h
  always_comb begin
    vert0_x = hx[0];
    vert0_y = hy[0];
    vert1_x = phase ? hx[2] : hx[1];
    vert1_y = phase ? hy[2] : hy[1];
    vert2_x = phase ? hx[3] : hx[2];
    vert2_y = phase ? hy[3] : hy[2];
    last_triangle = phase;
  end

endmodule

// ===== rtl/core/wide_line_quad_expander_core.sv =====
// Thick line to quad expander: one segment in, two triangles out.
// The time from push to first triangle varies with the normalize steps
// (right shifts by one, or left shifts by eight or by one) of each segment.
// The back engine works on one segment at a time, through the bit-serial
// root and divide/scale loops; further segments wait in the queue.
// Reset: synchronous rst clears the queue, engine state and result stage.
`include "wide_line_quad_expander_core_macros.svh"
module wide_line_quad_expander_core #(
  parameter int COORD_WIDTH = wlqe_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = wlqe_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic signed [COORD_WIDTH-1:0] start_x,
  input  logic signed [COORD_WIDTH-1:0] start_y,
  input  logic signed [COORD_WIDTH-1:0] end_x,
  input  logic signed [COORD_WIDTH-1:0] end_y,
  input  logic signed [COORD_WIDTH-1:0] line_width,
  input  logic                          pop,
  output logic                          empty,
  output logic signed [COORD_WIDTH-1:0] vert0_x,
  output logic signed [COORD_WIDTH-1:0] vert0_y,
  output logic signed [COORD_WIDTH-1:0] vert1_x,
  output logic signed [COORD_WIDTH-1:0] vert1_y,
  output logic signed [COORD_WIDTH-1:0] vert2_x,
  output logic signed [COORD_WIDTH-1:0] vert2_y,
  output logic                          last_triangle
);
  import wlqe_pkg::*;

  localparam int QW = 7 * COORD_WIDTH + 2;

  wlqe_q_stat_t           q_stat;
  logic                   q_push;
  logic                   q_pop;
  logic [QW-1:0]          q_wdata;
  logic [QW-1:0]          q_rdata;
  logic                   c_valid;
  logic                   c_ready;
  logic [COORD_WIDTH-1:0] cx [4];
  logic [COORD_WIDTH-1:0] cy [4];

  wlqe_front #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_front (
    .push(push), .full(full),
    .start_x(start_x), .start_y(start_y), .end_x(end_x), .end_y(end_y),
    .line_width(line_width),
    .q_stat(q_stat), .q_push(q_push), .q_data(q_wdata)
  );

  wlqe_queue #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk(clk), .rst(rst), .wr(q_push), .wdata(q_wdata),
    .rd(q_pop), .rdata(q_rdata), .stat(q_stat)
  );

  wlqe_back #(.COORD_WIDTH(COORD_WIDTH)) u_back (
    .clk(clk), .rst(rst), .q_stat(q_stat), .q_data(q_rdata), .q_pop(q_pop),
    .c_valid(c_valid), .c_ready(c_ready), .cx(cx), .cy(cy)
  );

  wlqe_emit #(.COORD_WIDTH(COORD_WIDTH)) u_emit (
    .clk(clk), .rst(rst), .c_valid(c_valid), .c_ready(c_ready),
    .cx(cx), .cy(cy), .pop(pop), .empty(empty),
    .vert0_x(vert0_x), .vert0_y(vert0_y), .vert1_x(vert1_x),
    .vert1_y(vert1_y), .vert2_x(vert2_x), .vert2_y(vert2_y),
    .last_triangle(last_triangle)
  );

  // the second triangle always follows the first
  `WLQE_ASSERT(a_second_follows, clk, rst, (pop && !empty && !last_triangle) |=> (!empty && last_triangle))
  // a zero-length segment never enters the queue
  `WLQE_ASSERT(a_zero_dropped, clk, rst, (start_x == end_x && start_y == end_y) |-> !q_push)
  // the queue is never full and empty at once
  `WLQE_ASSERT_NEVER(a_queue_stat, clk, rst, q_stat.full && q_stat.empty)

endmodule

// ===== sim/tb_wide_line_quad_expander_core.sv =====
// Testbench for the wide line quad expander: segments in, checked triangles out.
module tb_wide_line_quad_expander_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW = wlqe_pkg::COORD_WIDTH_DEF;
  localparam int FB = wlqe_pkg::FRAC_BITS_DEF;
  localparam longint CMAX = (64'sd1 <<< (CW - 1)) - 1;
  localparam longint CMIN = -CMAX - 1;

  typedef struct packed {
    logic [CW-1:0] v0x, v0y, v1x, v1y, v2x, v2y;
    logic          last;
  } tri_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic full, empty;
  logic signed [CW-1:0] start_x = '0, start_y = '0, end_x = '0, end_y = '0;
  logic signed [CW-1:0] line_width = '0;
  logic signed [CW-1:0] vert0_x, vert0_y, vert1_x, vert1_y, vert2_x, vert2_y;
  logic last_triangle;

  tri_t expected_tris[$];
  int mismatches = 0;
  int hold_off = 0;
  bit idle_enable = 1'b1;

  wide_line_quad_expander_core uut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Magnitude of a signed 64-bit value
  function automatic longint unsigned abs64(longint v);
    return v < 0 ? longint'(-v) : v;
  endfunction

  // Integer square root, bit by bit
  function automatic longint unsigned root64(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Half of width times unit component, rounded half away from zero
  function automatic longint half_offset(longint w, longint n);
    logic [127:0] prod;
    longint unsigned m;
    prod = 128'(abs64(w)) * 128'(abs64(n)) + (128'd1 << 30);
    m = 64'(prod >> 31);
    return ((w < 0) != (n < 0)) ? -longint'(m) : longint'(m);
  endfunction

  function automatic logic [CW-1:0] clamp(longint v);
    if (v > CMAX) v = CMAX;
    if (v < CMIN) v = CMIN;
    return v[CW-1:0];
  endfunction

  // Expand one segment into its two expected triangles
  task automatic predict_quad(longint sx, longint sy, longint ex, longint ey, longint w);
    longint dx, dy, ux, uy, hx, hy;
    longint unsigned ax, ay, m, len;
    logic [CW-1:0] c[4][2];
    tri_t t;
    dx = ex - sx;
    dy = ey - sy;
    if (dx == 0 && dy == 0) return;
    if (w <= 0) w = 64'sd1 <<< FB;
    ax = abs64(dx);
    ay = abs64(dy);
    m = ax > ay ? ax : ay;
    while (m >= (64'd1 << 30)) begin
      ax >>= 1; ay >>= 1; m >>= 1;
    end
    while (m < (64'd1 << 29)) begin
      ax <<= 1; ay <<= 1; m <<= 1;
    end
    len = root64(ax * ax + ay * ay);
    ux = ((ax << 30) + (len >> 1)) / len;
    uy = ((ay << 30) + (len >> 1)) / len;
    if (dx < 0) ux = -ux;
    if (dy < 0) uy = -uy;
    hx = half_offset(w, -uy);
    hy = half_offset(w, ux);
    c[0][0] = clamp(sx + hx); c[0][1] = clamp(sy + hy);
    c[1][0] = clamp(sx - hx); c[1][1] = clamp(sy - hy);
    c[2][0] = clamp(ex - hx); c[2][1] = clamp(ey - hy);
    c[3][0] = clamp(ex + hx); c[3][1] = clamp(ey + hy);
    t = '{c[0][0], c[0][1], c[1][0], c[1][1], c[2][0], c[2][1], 1'b0};
    expected_tris.push_back(t);
    t = '{c[0][0], c[0][1], c[2][0], c[2][1], c[3][0], c[3][1], 1'b1};
    expected_tris.push_back(t);
  endtask

  // Offer one segment until the block takes it; push stays high for the next one
  task automatic send_segment(logic [CW-1:0] sx, sy, ex, ey, w);
    while (idle_enable && $urandom_range(99) < 17) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push <= 1'b1;
    start_x <= sx; start_y <= sy; end_x <= ex; end_y <= ey; line_width <= w;
    @(posedge clk);
    while (full) @(posedge clk);
    predict_quad(signed'(sx), signed'(sy), signed'(ex), signed'(ey), signed'(w));
    @(negedge clk);
  endtask

  function automatic logic [CW-1:0] rand_coord();
    case ($urandom_range(5))
      0: return CMAX[CW-1:0];
      1: return CMIN[CW-1:0];
      2: return CW'($urandom_range(2000)) - CW'(1000);
      default: return CW'($urandom);
    endcase
  endfunction

  function automatic logic [CW-1:0] rand_width();
    case ($urandom_range(5))
      0: return '0;
      1: return CW'($urandom);
      2: return CMAX[CW-1:0];
      default: return CW'($urandom_range(20 << FB));
    endcase
  endfunction

  // Drive pop: random stalls, or a long hold-off when requested
  always @(negedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      pop <= 1'b0;
    end else begin
      pop <= !(idle_enable && $urandom_range(99) < 17);
    end
  end

  // Compare every transfer against the oldest expected triangle
  always @(posedge clk) begin
    tri_t got, want;
    if (!rst && pop && !empty) begin
      got = '{vert0_x, vert0_y, vert1_x, vert1_y, vert2_x, vert2_y, last_triangle};
      if (expected_tris.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected triangle %h", got);
      end else begin
        want = expected_tris.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("triangle mismatch: expected %h actual %h", want, got);
        end
      end
    end
  end

  // Drop push and wait until every expected triangle has come
  task automatic wait_drained();
    push <= 1'b0;
    while (expected_tris.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic test_directed();
    logic [CW-1:0] one;
    one = CW'(1) << FB;
    send_segment(0, 0, one, 0, one);
    send_segment(0, 0, 0, one, 2 * one);
    send_segment(one, one, one, one, one);          // zero length: nothing out
    send_segment(5, 7, 5, 7, 0);
    send_segment(0, 0, one, one, 0);                 // zero width becomes 1.0
    send_segment(0, 0, -one, 3 * one, CMIN[CW-1:0]); // negative width
    send_segment(CMIN[CW-1:0], CMIN[CW-1:0], CMAX[CW-1:0], CMAX[CW-1:0], CMAX[CW-1:0]);
    send_segment(CMAX[CW-1:0], 0, CMIN[CW-1:0], 0, CMAX[CW-1:0]);
    send_segment(0, CMAX[CW-1:0], 0, CMIN[CW-1:0], one);
    send_segment(0, 0, 1, 0, one);
    send_segment(0, 0, 0, -1, 3);
    send_segment(-1, -1, 0, 0, 1);
    send_segment('1, '1, '0, '0, '1);
    send_segment(CMAX[CW-1:0], CMAX[CW-1:0], CMAX[CW-1:0] - 1, CMAX[CW-1:0], CMAX[CW-1:0]);
    wait_drained();
  endtask

  task automatic test_random(int n);
    logic [CW-1:0] sx, sy;
    for (int i = 0; i < n; i++) begin
      sx = rand_coord();
      sy = rand_coord();
      if ($urandom_range(19) == 0)
        send_segment(sx, sy, sx, sy, rand_width());
      else
        send_segment(sx, sy, rand_coord(), rand_coord(), rand_width());
    end
  endtask

  // Hold off the receiver so the block fills and stalls its input
  task automatic test_backpressure();
    hold_off = 400;
    test_random(20);
    wait_drained();
  endtask

  task automatic test_no_idle();
    idle_enable = 1'b0;
    test_random(200);
    idle_enable = 1'b1;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_backpressure();
    test_random(800);
    wait_drained();   // sender pauses until all results have come
    test_no_idle();
    test_random(780);
    wait_drained();
    repeat (200) @(posedge clk);
    if (mismatches == 0 && expected_tris.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end
endmodule
